// ===== rtl/core/wlcg_pkg.sv =====
// shared types, constants and cosine table function for the windowed chirp generator
package wlcg_pkg;

    // configuration port geometry
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    // fixed field widths
    localparam int SAMPLE_BITS    = 16;
    localparam int COUNT_REG_BITS = 16;
    localparam int STEP_BITS      = 32;
    localparam int IN_TDATA_BITS  = 8;
    localparam int OUT_TDATA_BITS = 2 * SAMPLE_BITS;
    localparam int OUT_TUSER_BITS = 2;

    // fixed point
    localparam int          Q_BITS           = 30;
    localparam logic [63:0] Q30_ONE          = 64'h0000_0000_4000_0000;
    localparam logic [63:0] PI_HALF_Q30      = 64'd1686629713;
    // full scale 32767 is 2^15 - 1
    localparam int          FULL_SCALE_SHIFT = 15;

    // queue between sequencer and datapath
    localparam int QUEUE_DEPTH = 4;

    // register reset values
    localparam logic [COUNT_REG_BITS-1:0] RST_SAMPLES_PER_CHIRP = 16'd480;
    localparam logic [COUNT_REG_BITS-1:0] RST_CHIRP_COUNT       = 16'd1;
    localparam logic [STEP_BITS-1:0]      RST_WINDOW_STEP       = 32'd8966553;

    // register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SAMPLES_PER_CHIRP = 3'd0,
        CFG_CHIRP_COUNT       = 3'd1,
        CFG_START_STEP        = 3'd2,
        CFG_SWEEP_STEP        = 3'd3,
        CFG_WINDOW_STEP       = 3'd4,
        CFG_WINDOW_ENABLE     = 3'd5,
        CFG_SPEAKER_MODE      = 3'd6
    } t_cfg_idx;

    // speaker routing codes
    typedef enum logic [1:0] {
        SPK_RIGHT  = 2'd0,
        SPK_LEFT   = 2'd1,
        SPK_BOTH   = 2'd2,
        SPK_SILENT = 2'd3
    } t_spk_mode;

    // per-sample control word from sequencer to datapath
    typedef struct packed {
        logic window_en;
        logic left_en;
        logic right_en;
        logic burst_last;
        logic chirp_last;
        logic sample_valid;
    } t_flags;

    localparam int FLAGS_BITS = $bits(t_flags);

    // quarter-wave cosine in q30, angle x * (pi/2) / 2^qbits, taylor series to theta^12
    function automatic logic [30:0] quarter_cos(input logic [15:0] x, input int qbits);
        logic [63:0] theta;
        logic [63:0] t2;
        logic [63:0] acc;
        logic [63:0] term;
        logic [63:0] half;
        theta = (64'(x) * PI_HALF_Q30) >> qbits;
        t2    = (theta * theta) >> Q_BITS;
        acc   = Q30_ONE;
        term  = ((t2 * acc) >> Q_BITS) / 64'd132;
        acc   = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
        term  = ((t2 * acc) >> Q_BITS) / 64'd90;
        acc   = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
        term  = ((t2 * acc) >> Q_BITS) / 64'd56;
        acc   = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
        term  = ((t2 * acc) >> Q_BITS) / 64'd30;
        acc   = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
        term  = ((t2 * acc) >> Q_BITS) / 64'd12;
        acc   = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
        half  = ((t2 * acc) >> Q_BITS) >> 1;
        return (half >= Q30_ONE) ? 31'd0 : 31'(Q30_ONE - half);
    endfunction

endpackage

// ===== rtl/core/wlcg_front.sv =====
// burst sequencer: configuration registers, phase accumulators and sample counters
module wlcg_front
    import wlcg_pkg::*;
#(
    parameter int PHASE_BITS     = 32,
    parameter int COS_TABLE_BITS = 10,
    parameter int COUNT_BITS     = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]   i_cfg_addr,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_wdata,
    input  logic                      i_beat_valid,
    input  logic                      i_restart,
    output logic                      o_beat_ready,
    input  logic                      i_queue_ready,
    output logic                      o_push,
    output t_flags                    o_flags,
    output logic [COS_TABLE_BITS-1:0] o_tone_idx,
    output logic [COS_TABLE_BITS-1:0] o_win_idx
);

    // configuration registers
    logic [COUNT_REG_BITS-1:0] r_samples_per_chirp;
    logic [COUNT_REG_BITS-1:0] r_chirp_count;
    logic [STEP_BITS-1:0]      r_start_step;
    logic signed [STEP_BITS-1:0] r_sweep_step;
    logic [STEP_BITS-1:0]      r_window_step;
    logic                      r_window_enable;
    t_spk_mode                 r_speaker_mode;

    // sequencer state
    logic [PHASE_BITS-1:0] r_tone_phase, n_tone_phase;
    logic [PHASE_BITS-1:0] r_phase_inc,  n_phase_inc;
    logic [PHASE_BITS-1:0] r_win_phase,  n_win_phase;
    logic [COUNT_BITS-1:0] r_sample_idx, n_sample_idx;
    logic [COUNT_BITS-1:0] r_chirp_idx,  n_chirp_idx;
    logic                  r_running,    n_running;

    logic [PHASE_BITS-1:0] w_start_p, w_sweep_p, w_win_step_p, w_chirp_inc0;
    logic [PHASE_BITS-1:0] w_cur_tone, w_cur_inc, w_cur_win;
    logic [COUNT_BITS-1:0] w_cur_sidx, w_cur_cidx;
    logic [COUNT_BITS-1:0] w_n_lim, w_cnt, w_last_sample, w_last_chirp;
    logic                  w_cur_running, w_silent, w_chirp_last, w_burst_last, w_fire;
    t_flags                w_flags;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_samples_per_chirp <= RST_SAMPLES_PER_CHIRP;
            r_chirp_count       <= RST_CHIRP_COUNT;
            r_start_step        <= '0;
            r_sweep_step        <= '0;
            r_window_step       <= RST_WINDOW_STEP;
            r_window_enable     <= 1'b1;
            r_speaker_mode      <= SPK_BOTH;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_SAMPLES_PER_CHIRP: r_samples_per_chirp <= i_cfg_wdata[COUNT_REG_BITS-1:0];
                CFG_CHIRP_COUNT:       r_chirp_count       <= i_cfg_wdata[COUNT_REG_BITS-1:0];
                CFG_START_STEP:        r_start_step        <= i_cfg_wdata[STEP_BITS-1:0];
                CFG_SWEEP_STEP:        r_sweep_step        <= signed'(i_cfg_wdata[STEP_BITS-1:0]);
                CFG_WINDOW_STEP:       r_window_step       <= i_cfg_wdata[STEP_BITS-1:0];
                CFG_WINDOW_ENABLE:     r_window_enable     <= i_cfg_wdata[0];
                CFG_SPEAKER_MODE:      r_speaker_mode      <= t_spk_mode'(i_cfg_wdata[1:0]);
                default: ;
            endcase
        end
    end

    // steps and limits at accumulator and counter width
    assign w_start_p     = PHASE_BITS'(r_start_step);
    assign w_sweep_p     = PHASE_BITS'(r_sweep_step);
    assign w_win_step_p  = PHASE_BITS'(r_window_step);
    assign w_chirp_inc0  = w_start_p + w_sweep_p;
    assign w_cnt         = COUNT_BITS'(r_chirp_count);
    assign w_last_chirp  = w_cnt - 1'b1;
    assign w_n_lim       = (COUNT_BITS'(r_samples_per_chirp) == '0) ?
                           COUNT_BITS'(1) : COUNT_BITS'(r_samples_per_chirp);
    assign w_last_sample = w_n_lim - 1'b1;

    // state as seen by this beat, after an optional restart
    assign w_cur_tone    = i_restart ? '0 : r_tone_phase;
    assign w_cur_inc     = i_restart ? w_chirp_inc0 : r_phase_inc;
    assign w_cur_win     = i_restart ? '0 : r_win_phase;
    assign w_cur_sidx    = i_restart ? '0 : r_sample_idx;
    assign w_cur_cidx    = i_restart ? '0 : r_chirp_idx;
    assign w_cur_running = i_restart ? (w_cnt != '0) : r_running;

    // a chirp count of zero written mid-burst never ends the burst
    assign w_silent     = (r_speaker_mode == SPK_SILENT);
    assign w_chirp_last = (w_cur_sidx >= w_last_sample);
    assign w_burst_last = w_chirp_last && (w_cnt != '0) && (w_cur_cidx >= w_last_chirp);

    // classify the beat
    always_comb begin
        w_flags = '0;
        if (w_cur_running) begin
            w_flags.sample_valid = 1'b1;
            if (w_silent) begin
                w_flags.chirp_last = 1'b1;
                w_flags.burst_last = 1'b1;
            end else begin
                w_flags.chirp_last = w_chirp_last;
                w_flags.burst_last = w_burst_last;
                w_flags.left_en    = (r_speaker_mode != SPK_RIGHT);
                w_flags.right_en   = (r_speaker_mode != SPK_LEFT);
                w_flags.window_en  = r_window_enable;
            end
        end
    end

    // advance accumulators and counters
    always_comb begin
        n_tone_phase = w_cur_tone;
        n_phase_inc  = w_cur_inc;
        n_win_phase  = w_cur_win;
        n_sample_idx = w_cur_sidx;
        n_chirp_idx  = w_cur_cidx;
        n_running    = w_cur_running;
        if (w_cur_running) begin
            priority if (w_silent || w_burst_last) begin
                n_running = 1'b0;
            end else if (w_chirp_last) begin
                n_chirp_idx  = w_cur_cidx + 1'b1;
                n_tone_phase = '0;
                n_phase_inc  = w_chirp_inc0;
                n_win_phase  = '0;
                n_sample_idx = '0;
            end else begin
                n_tone_phase = w_cur_tone + w_cur_inc;
                n_phase_inc  = w_cur_inc + {w_sweep_p[PHASE_BITS-2:0], 1'b0};
                n_win_phase  = w_cur_win + w_win_step_p;
                n_sample_idx = w_cur_sidx + 1'b1;
            end
        end
    end

    assign w_fire = i_beat_valid && i_queue_ready;

    // sequencer state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone_phase <= '0;
            r_phase_inc  <= '0;
            r_win_phase  <= '0;
            r_sample_idx <= '0;
            r_chirp_idx  <= '0;
            r_running    <= 1'b0;
        end else if (w_fire) begin
            r_tone_phase <= n_tone_phase;
            r_phase_inc  <= n_phase_inc;
            r_win_phase  <= n_win_phase;
            r_sample_idx <= n_sample_idx;
            r_chirp_idx  <= n_chirp_idx;
            r_running    <= n_running;
        end
    end

    assign o_beat_ready = i_queue_ready;
    assign o_push       = w_fire;
    assign o_flags      = w_flags;
    assign o_tone_idx   = w_cur_tone[PHASE_BITS-1 -: COS_TABLE_BITS];
    assign o_win_idx    = w_cur_win[PHASE_BITS-1 -: COS_TABLE_BITS];

endmodule

// ===== rtl/core/wlcg_queue.sv =====
// short fifo between the sequencer and the sample datapath
module wlcg_queue
    import wlcg_pkg::*;
#(
    parameter int WIDTH = 26
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic                w_do_push, w_do_pop;

    assign o_ready   = (r_count != CNT_BITS'(QUEUE_DEPTH));
    assign o_valid   = (r_count != '0);
    assign w_do_push = i_push && o_ready;
    assign w_do_pop  = i_pop && o_valid;
    assign o_data    = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/core/wlcg_back.sv =====
// sample datapath: cosine lookups, hann gain, scaling, routing and output register
module wlcg_back
    import wlcg_pkg::*;
#(
    parameter int COS_TABLE_BITS = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_item_valid,
    output logic                        o_item_pop,
    input  t_flags                      i_flags,
    input  logic [COS_TABLE_BITS-1:0]   i_tone_idx,
    input  logic [COS_TABLE_BITS-1:0]   i_win_idx,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [OUT_TDATA_BITS-1:0]   m_axis_tdata,
    output logic [OUT_TUSER_BITS-1:0]   m_axis_tuser,
    output logic                        m_axis_tlast
);

    localparam int          QBITS   = COS_TABLE_BITS - 2;
    localparam int          QSIZE   = 1 << QBITS;
    localparam logic [30:0] Q_EDGE  = quarter_cos(16'(QSIZE), QBITS);
    localparam logic [31:0] ONE_Q30 = 32'(Q30_ONE);
    localparam int          MAG_BITS = FULL_SCALE_SHIFT;

    // quarter-wave cosine table, built at elaboration
    logic [30:0] w_qtab [QSIZE];
    for (genvar g = 0; g < QSIZE; g++) begin : g_qtab
        localparam logic [30:0] V = quarter_cos(16'(g), QBITS);
        assign w_qtab[g] = V;
    end

    // pipeline control: whole pipe holds while the output beat waits
    logic w_advance;
    logic r1_valid, r2_valid, r3_valid, r4_valid, r_out_valid;

    assign w_advance  = !(r_out_valid && !m_axis_tready);
    assign o_item_pop = w_advance && i_item_valid;

    // tone lookup with quarter-wave symmetry
    logic [1:0]       w_t_quad, w_w_quad;
    logic [QBITS-1:0] w_t_r, w_w_r, w_t_addr, w_w_addr;
    logic [30:0]      w_t_mag, w_w_mag;

    assign w_t_quad = i_tone_idx[COS_TABLE_BITS-1 -: 2];
    assign w_t_r    = i_tone_idx[QBITS-1:0];
    assign w_t_addr = w_t_quad[0] ? QBITS'(~w_t_r + 1'b1) : w_t_r;
    assign w_t_mag  = (w_t_quad[0] && (w_t_r == '0)) ? Q_EDGE : w_qtab[w_t_addr];

    // window lookup
    assign w_w_quad = i_win_idx[COS_TABLE_BITS-1 -: 2];
    assign w_w_r    = i_win_idx[QBITS-1:0];
    assign w_w_addr = w_w_quad[0] ? QBITS'(~w_w_r + 1'b1) : w_w_r;
    assign w_w_mag  = (w_w_quad[0] && (w_w_r == '0)) ? Q_EDGE : w_qtab[w_w_addr];

    // stage 1: table outputs
    t_flags      r1_flags;
    logic [30:0] r1_cmag, r1_wmag;
    logic        r1_csign, r1_wsign;

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r1_flags <= i_flags;
            r1_cmag  <= w_t_mag;
            r1_csign <= w_t_quad[0] ^ w_t_quad[1];
            r1_wmag  <= w_w_mag;
            r1_wsign <= w_w_quad[0] ^ w_w_quad[1];
        end
    end

    // stage 2: hann gain (1 - cos) / 2 in q30
    logic [31:0] w_w_sum;
    logic [30:0] w_gain;
    t_flags      r2_flags;
    logic [30:0] r2_gain, r2_cmag;
    logic        r2_csign;

    assign w_w_sum = r1_wsign ? ONE_Q30 + 32'(r1_wmag) : ONE_Q30 - 32'(r1_wmag);
    assign w_gain  = r1_flags.window_en ? 31'(w_w_sum >> 1) : 31'(ONE_Q30);

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r2_flags <= r1_flags;
            r2_gain  <= w_gain;
            r2_cmag  <= r1_cmag;
            r2_csign <= r1_csign;
        end
    end

    // stage 3: gain times cosine magnitude
    logic [61:0] w_prod;
    t_flags      r3_flags;
    logic [30:0] r3_m1;
    logic        r3_csign;

    assign w_prod = 62'(r2_gain) * 62'(r2_cmag);

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r3_flags <= r2_flags;
            r3_m1    <= 31'(w_prod >> Q_BITS);
            r3_csign <= r2_csign;
        end
    end

    // stage 4: scale to full range by shift and subtract
    logic [45:0]         w_scaled;
    t_flags              r4_flags;
    logic [MAG_BITS-1:0] r4_mag;
    logic                r4_csign;

    assign w_scaled = (46'(r3_m1) << FULL_SCALE_SHIFT) - 46'(r3_m1);

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r4_flags <= r3_flags;
            r4_mag   <= MAG_BITS'(w_scaled >> Q_BITS);
            r4_csign <= r3_csign;
        end
    end

    // output stage: sign and channel routing
    logic [SAMPLE_BITS-1:0]    w_pos, w_val, w_left, w_right;
    logic [OUT_TDATA_BITS-1:0] r_out_data;
    logic [OUT_TUSER_BITS-1:0] r_out_user;
    logic                      r_out_last;

    assign w_pos   = SAMPLE_BITS'(r4_mag);
    assign w_val   = r4_csign ? (~w_pos + 1'b1) : w_pos;
    assign w_left  = r4_flags.left_en  ? w_val : '0;
    assign w_right = r4_flags.right_en ? w_val : '0;

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= {w_right, w_left};
            r_out_user <= {r4_flags.chirp_last, r4_flags.sample_valid};
            r_out_last <= r4_flags.burst_last;
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r1_valid    <= i_item_valid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r4_valid    <= r3_valid;
            r_out_valid <= r4_valid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== rtl/core/windowed_linear_chirp_generator.sv =====
// top level of the windowed linear chirp generator
//
// Every beat on the slave stream asks for one stereo sample; tdata bit 0 is
// restart, which starts a new burst at sample zero in that beat. Every
// accepted beat yields exactly one master beat, in order: an idle beat (all
// zero, sample_valid low) when no burst runs, otherwise one sample of the
// current chirp. Registers are written through the plain write port; the user
// must write them only while the block is idle, which the block does not enforce.
// Throughput is one beat per cycle while the master side does not stall. The
// sequencer takes a beat whenever the four-entry queue has room and pushes it
// into the queue in the same cycle; the datapath (two cosine table reads, hann
// gain, two scaling steps, routing) is five registered stages.
// When the master side stalls, the datapath holds in place and the queue
// fills; s_axis_tready drops once four beats are waiting.
// Reset is synchronous and active low: registers return to their reset
// values, the burst is idle and the pipeline and queue are empty.
module windowed_linear_chirp_generator
    import wlcg_pkg::*;
#(
    parameter int PHASE_BITS     = 32,
    parameter int COS_TABLE_BITS = 10,
    parameter int COUNT_BITS     = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration write port
    input  logic                      i_cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]   i_cfg_addr,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_wdata,
    // request stream
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,   // [0] restart, [7:1] zero
    // sample stream
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,   // [15:0] left_sample, [31:16] right_sample
    output logic [OUT_TUSER_BITS-1:0] m_axis_tuser,   // [0] sample_valid, [1] chirp_last
    output logic                      m_axis_tlast    // burst_last
);

    localparam int QW = FLAGS_BITS + 2 * COS_TABLE_BITS;

    logic                      w_queue_ready, w_push, w_pop, w_item_valid;
    t_flags                    w_front_flags, w_back_flags;
    logic [COS_TABLE_BITS-1:0] w_front_tone, w_front_win;
    logic [COS_TABLE_BITS-1:0] w_back_tone, w_back_win;
    logic [QW-1:0]             w_push_data, w_pop_data;

    // sequencer
    wlcg_front #(
        .PHASE_BITS     (PHASE_BITS),
        .COS_TABLE_BITS (COS_TABLE_BITS),
        .COUNT_BITS     (COUNT_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_beat_valid  (s_axis_tvalid),
        .i_restart     (s_axis_tdata[0]),
        .o_beat_ready  (s_axis_tready),
        .i_queue_ready (w_queue_ready),
        .o_push        (w_push),
        .o_flags       (w_front_flags),
        .o_tone_idx    (w_front_tone),
        .o_win_idx     (w_front_win)
    );

    // queue between sequencer and datapath
    assign w_push_data = {w_front_flags, w_front_tone, w_front_win};

    wlcg_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_ready (w_queue_ready),
        .i_pop   (w_pop),
        .o_valid (w_item_valid),
        .o_data  (w_pop_data)
    );

    assign w_back_flags = t_flags'(w_pop_data[QW-1 -: FLAGS_BITS]);
    assign w_back_tone  = w_pop_data[2*COS_TABLE_BITS-1 -: COS_TABLE_BITS];
    assign w_back_win   = w_pop_data[COS_TABLE_BITS-1:0];

    // sample datapath
    wlcg_back #(
        .COS_TABLE_BITS (COS_TABLE_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (w_item_valid),
        .o_item_pop    (w_pop),
        .i_flags       (w_back_flags),
        .i_tone_idx    (w_back_tone),
        .i_win_idx     (w_back_win),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== rtl/core/wlcg_checker.sv =====
// port-level assertions for the chirp generator and their binding
module wlcg_checker
    import wlcg_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
    input logic [OUT_TUSER_BITS-1:0] m_axis_tuser,
    input logic                      m_axis_tlast
);

    // pipeline is empty right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !m_axis_tvalid)
        else $error("sample beat present right after reset");

    // end of burst is always the end of a chirp of a running burst
    a_burst_end_is_chirp_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1] && m_axis_tuser[0])
        else $error("burst_last without chirp_last and sample_valid");

    // idle beats carry nothing
    a_idle_beat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            (m_axis_tdata == '0) && !m_axis_tuser[1] && !m_axis_tlast)
        else $error("idle beat with nonzero fields");

    // magnitude never reaches the most negative code
    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[15:0] != 16'h8000) && (m_axis_tdata[31:16] != 16'h8000))
        else $error("sample outside full scale");

    // a stalled sample beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("sample beat changed while stalled");

endmodule

bind windowed_linear_chirp_generator wlcg_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/sv/windowed_linear_chirp_generator_tb.sv =====
// self-checking testbench for the windowed linear chirp generator
module windowed_linear_chirp_generator_tb;
    import wlcg_pkg::*;

    localparam int     TOTAL_ITEMS   = 1550;
    localparam int     QUIET_LIMIT   = 1000;
    localparam int     LONG_HOLD     = 100;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     TAIL_CYCLES   = 20;
    localparam longint ONE_Q30       = 64'd1073741824;
    localparam longint HALF_PI_Q30   = 64'd1686629713;
    localparam int     QUARTER_SIZE  = 256;

    // one sample beat as seen on the master side
    typedef struct packed {
        logic [15:0] left;
        logic [15:0] right;
        logic        valid;
        logic        chirp_last;
        logic        burst_last;
    } t_chirp_beat;

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_BITS-1:0]   i_cfg_addr    = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_wdata   = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata  = '0;   // [0] restart, [7:1] zero
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;         // [15:0] left_sample, [31:16] right_sample
    logic [OUT_TUSER_BITS-1:0] m_axis_tuser;         // [0] sample_valid, [1] chirp_last
    logic                      m_axis_tlast;         // burst_last

    windowed_linear_chirp_generator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // predictor registers
    logic [15:0] cfg_len   = RST_SAMPLES_PER_CHIRP;
    logic [15:0] cfg_count = RST_CHIRP_COUNT;
    logic [31:0] cfg_start = '0;
    logic [31:0] cfg_sweep = '0;
    logic [31:0] cfg_wstep = RST_WINDOW_STEP;
    logic        cfg_wen   = 1'b1;
    t_spk_mode   cfg_mode  = SPK_BOTH;

    // predictor burst state
    logic [31:0] tone_acc  = '0;
    logic [31:0] tone_inc  = '0;
    logic [31:0] win_acc   = '0;
    logic [15:0] smp_idx   = '0;
    logic [15:0] chirp_idx = '0;
    logic        busy      = 1'b0;

    longint      quarter_lut [0:QUARTER_SIZE];
    t_chirp_beat expected_samples [$];

    int err_cnt      = 0;
    int quiet_cycles = 0;
    int tx_count     = 0;
    int tx_run       = 0;
    int hold_token   = 0;
    int hold_seen    = 0;
    int rx_hold      = 0;
    int rx_run       = 0;

    // quarter-wave cosine in q30 by a truncated taylor series, clamped at zero
    function automatic longint quarter_wave(input int x);
        longint unsigned th;
        longint unsigned th2;
        longint unsigned acc;
        longint unsigned term;
        longint unsigned half;
        th  = (longint'(x) * HALF_PI_Q30) >> 8;
        th2 = (th * th) >> 30;
        acc = ONE_Q30;
        for (int k = 6; k >= 2; k--) begin
            term = ((th2 * acc) >> 30) / longint'((2 * k) * (2 * k - 1));
            acc  = (term >= ONE_Q30) ? 64'd0 : ONE_Q30 - term;
        end
        half = ((th2 * acc) >> 30) / 2;
        return (half >= ONE_Q30) ? 64'sd0 : longint'(ONE_Q30 - half);
    endfunction

    // full-circle cosine from the top ten phase bits
    function automatic longint lut_cos(input logic [31:0] ph);
        int r;
        r = int'(ph[29:22]);
        case (ph[31:30])
            2'd0:    return quarter_lut[r];
            2'd1:    return -quarter_lut[QUARTER_SIZE - r];
            2'd2:    return -quarter_lut[r];
            default: return quarter_lut[QUARTER_SIZE - r];
        endcase
    endfunction

    function automatic void restart_chirp();
        tone_acc = '0;
        tone_inc = cfg_start + cfg_sweep;
        win_acc  = '0;
        smp_idx  = '0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_BITS-1:0] addr,
                                      input logic [31:0] val);
        case (t_cfg_idx'(addr))
            CFG_SAMPLES_PER_CHIRP: cfg_len   = val[15:0];
            CFG_CHIRP_COUNT:       cfg_count = val[15:0];
            CFG_START_STEP:        cfg_start = val;
            CFG_SWEEP_STEP:        cfg_sweep = val;
            CFG_WINDOW_STEP:       cfg_wstep = val;
            CFG_WINDOW_ENABLE:     cfg_wen   = val[0];
            CFG_SPEAKER_MODE:      cfg_mode  = t_spk_mode'(val[1:0]);
            default: ;
        endcase
    endfunction

    // next stereo sample of the burst, advancing the accumulators
    function automatic t_chirp_beat predict_chirp_sample(input logic restart);
        t_chirp_beat res;
        logic [16:0] n;
        longint      c;
        longint      w;
        longint      mag;
        longint      m;
        logic [15:0] val;
        res = '0;
        if (restart) begin
            restart_chirp();
            chirp_idx = '0;
            busy      = (cfg_count != 0);
        end
        if (!busy)
            return res;
        n = (cfg_len == 0) ? 17'd1 : 17'(cfg_len);
        // invalid routing gives one silent closing beat
        if (cfg_mode == SPK_SILENT) begin
            res.valid      = 1'b1;
            res.chirp_last = 1'b1;
            res.burst_last = 1'b1;
            busy           = 1'b0;
            return res;
        end
        c   = lut_cos(tone_acc);
        w   = cfg_wen ? (ONE_Q30 - lut_cos(win_acc)) / 2 : ONE_Q30;
        mag = (c < 0) ? -c : c;
        m   = (w * mag) >>> 30;
        m   = (m * 32767) >>> 30;
        val = (c < 0) ? 16'(-m) : 16'(m);
        if (cfg_mode != SPK_RIGHT)
            res.left = val;
        if (cfg_mode != SPK_LEFT)
            res.right = val;
        res.valid      = 1'b1;
        res.chirp_last = (17'(smp_idx) >= n - 17'd1);
        res.burst_last = res.chirp_last && (cfg_count != 0) && (chirp_idx >= cfg_count - 16'd1);
        if (res.burst_last) begin
            busy = 1'b0;
        end else if (res.chirp_last) begin
            chirp_idx = chirp_idx + 16'd1;
            restart_chirp();
        end else begin
            tone_acc = tone_acc + tone_inc;
            tone_inc = tone_inc + {cfg_sweep[30:0], 1'b0};
            win_acc  = win_acc + cfg_wstep;
            smp_idx  = smp_idx + 16'd1;
        end
        return res;
    endfunction

    task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
        if (want !== got) begin
            err_cnt++;
            $display("%0t mismatch %s: expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    // monitor: register writes, request beats, sample beats, watchdog
    always @(posedge i_clk) begin
        t_chirp_beat want;
        t_chirp_beat got;
        t_chirp_beat pred;
        logic        moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_cfg_wr_en) begin
                apply_reg(i_cfg_addr, i_cfg_wdata);
                moved = 1'b1;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pred = predict_chirp_sample(s_axis_tdata[0]);
                expected_samples = {expected_samples, pred};
                moved = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                moved = 1'b1;
                got.left       = m_axis_tdata[15:0];
                got.right      = m_axis_tdata[31:16];
                got.valid      = m_axis_tuser[0];
                got.chirp_last = m_axis_tuser[1];
                got.burst_last = m_axis_tlast;
                if (expected_samples.size() == 0) begin
                    err_cnt++;
                    $display("%0t unexpected sample beat: expected none, actual %h", $time, got);
                end else begin
                    want = expected_samples.pop_front();
                    check_field("left_sample", want.left, got.left);
                    check_field("right_sample", want.right, got.right);
                    check_field("sample_valid", 16'(want.valid), 16'(got.valid));
                    check_field("chirp_last", 16'(want.chirp_last), 16'(got.chirp_last));
                    check_field("burst_last", 16'(want.burst_last), 16'(got.burst_last));
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // sample side ready: random stalls, forced long hold, stall-free stretches
    always @(posedge i_clk) begin
        int r;
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            rx_hold   = LONG_HOLD;
            rx_run    = 0;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else if (rx_run > 0) begin
            rx_run--;
            m_axis_tready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                rx_run = $urandom_range(20, 60);
                m_axis_tready <= 1'b1;
            end else if (r < 7) begin
                rx_hold = $urandom_range(8, 30);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // offer one request beat after a random gap and wait for it to be taken
    task automatic send_beat(input logic restart);
        int gap;
        int r;
        gap = 0;
        if (tx_run > 0) begin
            tx_run--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 4)
                tx_run = $urandom_range(10, 50);
            else if (r < 8)
                gap = $urandom_range(8, 30);
            else if (r < 45)
                gap = $urandom_range(1, 3);
        end
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_BITS'(restart);
        do @(posedge i_clk); while (!s_axis_tready);
        tx_count++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    // write the selected registers once the block has gone quiet
    task automatic set_regs(input logic [6:0] mask, input logic [15:0] len,
                            input logic [15:0] count, input logic [31:0] start,
                            input logic [31:0] sweep, input logic [31:0] wstep,
                            input logic wen, input t_spk_mode mode);
        wait_drained();
        if (mask[CFG_SAMPLES_PER_CHIRP]) write_reg(CFG_SAMPLES_PER_CHIRP, 32'(len));
        if (mask[CFG_CHIRP_COUNT])       write_reg(CFG_CHIRP_COUNT, 32'(count));
        if (mask[CFG_START_STEP])        write_reg(CFG_START_STEP, start);
        if (mask[CFG_SWEEP_STEP])        write_reg(CFG_SWEEP_STEP, sweep);
        if (mask[CFG_WINDOW_STEP])       write_reg(CFG_WINDOW_STEP, wstep);
        if (mask[CFG_WINDOW_ENABLE])     write_reg(CFG_WINDOW_ENABLE, 32'(wen));
        if (mask[CFG_SPEAKER_MODE])      write_reg(CFG_SPEAKER_MODE, 32'(mode));
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_chirp_beats(input int beats);
        send_beat(1'b1);
        repeat (beats - 1) send_beat(1'b0);
    endtask

    task automatic test_idle_after_reset();
        send_beat(1'b0);
        send_beat(1'b0);
    endtask

    // right only, left only, then both with the window off over two chirps
    task automatic test_routing();
        set_regs(7'h7F, 16'd4, 16'd1, 32'h0400_0000, 32'h0010_0000, 32'h5555_5555,
                 1'b1, SPK_RIGHT);
        send_chirp_beats(4);
        set_regs(7'h7F, 16'd4, 16'd1, 32'h0400_0000, 32'h0010_0000, 32'h5555_5555,
                 1'b1, SPK_LEFT);
        send_chirp_beats(4);
        set_regs(7'h7F, 16'd2, 16'd2, 32'h1234_5678, 32'hFFF0_0000, 32'h5555_5555,
                 1'b0, SPK_BOTH);
        send_chirp_beats(5);
    endtask

    // zero chirp count, zero chirp length, invalid routing
    task automatic test_corner_cases();
        set_regs(7'h7F, 16'd3, 16'd0, 32'h0100_0000, 32'h0, 32'h8000_0000, 1'b1, SPK_BOTH);
        send_beat(1'b1);
        set_regs(7'h7F, 16'd0, 16'd2, 32'h0100_0000, 32'h0, 32'h8000_0000, 1'b1, SPK_BOTH);
        send_chirp_beats(3);
        set_regs(7'h7F, 16'd5, 16'd3, 32'h0100_0000, 32'h0, 32'h8000_0000, 1'b1, SPK_SILENT);
        send_chirp_beats(2);
    endtask

    // phase step extremes on both accumulators
    task automatic test_step_extremes();
        set_regs(7'h7F, 16'd3, 16'd1, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                 1'b1, SPK_BOTH);
        send_chirp_beats(3);
        set_regs(7'h7F, 16'd2, 16'd1, 32'h0, 32'h7FFF_FFFF, 32'h0, 1'b1, SPK_BOTH);
        send_chirp_beats(2);
    endtask

    // largest length and count, then shrink the length while the burst runs
    task automatic test_large_sizes();
        set_regs(7'h7F, 16'hFFFF, 16'hFFFF, $urandom, $urandom, $urandom, 1'b1, SPK_BOTH);
        send_chirp_beats(40);
        set_regs(7'h01, 16'd2, 16'd0, 32'h0, 32'h0, 32'h0, 1'b0, SPK_BOTH);
        repeat (30) send_beat(1'b0);
        send_chirp_beats(10);
    endtask

    // long receiver hold so the block fills, then wait for every sample
    task automatic test_backpressure();
        set_regs(7'h7F, 16'd5, 16'd3, 32'h0200_0000, 32'h0000_1000, 32'h4000_0000,
                 1'b1, SPK_BOTH);
        hold_token++;
        tx_run = 40;
        send_chirp_beats(40);
        wait_drained();
    endtask

    // random settings, bursts with random restarts
    task automatic test_random_bursts();
        logic [6:0]  mask;
        logic [15:0] len;
        logic [15:0] count;
        logic [31:0] start;
        logic [31:0] sweep;
        logic [31:0] wstep;
        int          r;
        int          beats;
        while (tx_count < TOTAL_ITEMS) begin
            mask = 7'($urandom) | (7'd1 << $urandom_range(0, 6));
            r = $urandom_range(0, 99);
            if (r < 70)      len = 16'($urandom_range(2, 24));
            else if (r < 80) len = 16'($urandom_range(0, 1));
            else if (r < 95) len = 16'($urandom_range(25, 300));
            else             len = 16'($urandom_range(16'hFFFE, 16'hFFFF));
            r = $urandom_range(0, 99);
            if (r < 60)      count = 16'($urandom_range(1, 4));
            else if (r < 75) count = 16'd0;
            else if (r < 90) count = 16'($urandom_range(5, 40));
            else             count = 16'hFFFF;
            r = $urandom_range(0, 99);
            if (r < 40)      start = $urandom;
            else if (r < 60) start = 32'h0;
            else if (r < 80) start = 32'h8000_0000;
            else             start = $urandom_range(0, 32'h0400_0000);
            r = $urandom_range(0, 99);
            if (r < 30)      sweep = $urandom;
            else if (r < 60) sweep = 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
            else if (r < 70) sweep = 32'h8000_0000;
            else if (r < 80) sweep = 32'h7FFF_FFFF;
            else             sweep = 32'h0;
            r = $urandom_range(0, 99);
            if (r < 50)      wstep = $urandom;
            else if (r < 85) wstep = (len > 1) ? 32'((64'd1 << 32) / (len - 1)) : 32'h0;
            else if (r < 93) wstep = 32'h0;
            else             wstep = 32'hFFFF_FFFF;
            set_regs(mask, len, count, start, sweep, wstep, 1'($urandom),
                     ($urandom_range(0, 99) < 85) ? t_spk_mode'($urandom_range(0, 2))
                                                  : SPK_SILENT);
            beats = $urandom_range(30, 120);
            send_beat(1'b1);
            repeat (beats - 1) send_beat($urandom_range(0, 99) < 3);
        end
    endtask

    initial begin
        for (int x = 0; x <= QUARTER_SIZE; x++)
            quarter_lut[x] = quarter_wave(x);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_after_reset();
        test_routing();
        test_corner_cases();
        test_step_extremes();
        test_large_sizes();
        test_backpressure();
        test_random_bursts();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && expected_samples.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== windowed_linear_chirp_generator.f =====
rtl/core/wlcg_pkg.sv
rtl/core/wlcg_front.sv
rtl/core/wlcg_queue.sv
rtl/core/wlcg_back.sv
rtl/core/windowed_linear_chirp_generator.sv
rtl/core/wlcg_checker.sv
tb/sv/windowed_linear_chirp_generator_tb.sv
